>>> rtl/dual_char_lcd_stream_sender_defines.svh
// Assertion macros for the checker file of the stream sender.
`ifndef DUAL_CHAR_LCD_STREAM_SENDER_DEFINES_SVH
`define DUAL_CHAR_LCD_STREAM_SENDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DCL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("dcl assertion failed");

// Next-cycle implication, disabled while reset is held.
`define DCL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dcl assertion failed");

`endif

>>> rtl/dcl_pkg.sv
// Package of the dual character-LCD stream sender: sizes, codes, types, helpers.
`default_nettype none
package dcl_pkg;

  localparam int unsigned FIFO_DEPTH = 64;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned WAIT_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NIB_W      = 4;

  localparam logic [WAIT_W-1:0] SHORT_WAIT_RST = WAIT_W'(38);
  localparam logic [WAIT_W-1:0] LONG_WAIT_RST  = WAIT_W'(1520);

  // Configuration register indexes
  localparam logic REG_SHORT_WAIT = 1'b0;
  localparam logic REG_LONG_WAIT  = 1'b1;

  // Request kinds carried in tuser
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // tuser width of a result
  localparam int unsigned RES_USER_W = 3;

  typedef struct packed {
    logic [NIB_W-1:0] nibble;
    logic             reg_sel;
    logic             display;
    logic             dropped;
    logic             last;
  } result_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> rtl/dual_char_lcd_stream_sender.sv
// Top level of the dual character-LCD stream sender.
`default_nettype none
// Queues bytes for two 4-bit character displays and strobes them out as nibble
// pairs. A request with tuser 0 enqueues tdata into a ring FIFO that holds
// FIFO_DEPTH-1 bytes; a byte that meets a full FIFO is dropped and answered by
// one result with the dropped flag. A request with tuser 1 is one time tick:
// it counts the wait down, or, with the wait at zero and the FIFO not empty,
// pops one byte. Outside a command, a byte above 127 is a prefix whose bit 0
// picks the display and makes the next byte a command; any other byte leaves
// as high then low nibble (RS low for a command) and reloads the wait, long
// for commands 0 to 3, short otherwise. Rate: enqueues and ticks that pop
// nothing are taken back to back, one per cycle, while the output buffer
// has room. A popping tick reads the FIFO memory into a register, and its
// byte is decoded in the cycle after; the next request is taken once that
// decode is done. Results leave through a two-entry output buffer, which a
// sent byte fills with its two nibbles; a popping tick waits there only if
// earlier results have not been taken. Configuration writes apply at once.
module dual_char_lcd_stream_sender (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dcl_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
  input  logic                           s_axis_tuser,   // [0] op
  // result channel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [dcl_pkg::BYTE_W-1:0]     m_axis_tdata,   // [3:0] nibble, [7:4] zero
  output logic [dcl_pkg::RES_USER_W-1:0] m_axis_tuser,   // [0] reg_sel, [1] display,
                                                         // [2] dropped
  output logic                           m_axis_tlast,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [dcl_pkg::WAIT_W-1:0]     cfg_wdata_i
);
  import dcl_pkg::*;

  // configuration
  logic [WAIT_W-1:0] short_wait_q, long_wait_q;

  // FIFO memory and pointers
  logic [BYTE_W-1:0] mem_q [FIFO_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;

  // sequencing state
  logic              disp_sel_q, disp_sel_d;
  logic              cmd_pend_q, cmd_pend_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic              pop_q, pop_d;   // popped byte sits in rd_data_q

  // output buffer, entry 0 is the head
  result_t           ob_q [2];
  result_t           ob_d [2];
  logic [1:0]        ob_cnt_q, ob_cnt_d;

  logic    in_acc, out_acc;
  logic    fifo_full, fifo_empty;
  logic    mem_we, mem_re;
  logic    drop_push, send_push, room2;
  logic    rs;
  result_t drop_res, hi_res, lo_res;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_acc    = m_axis_tvalid && m_axis_tready;
  assign fifo_full  = (ptr_next(wr_ptr_q) == rd_ptr_q);
  assign fifo_empty = (rd_ptr_q == wr_ptr_q);

  // Hold requests while a popped byte awaits decode or the buffer is full.
  assign s_axis_tready = !pop_q && ((ob_cnt_q != 2'd2) || out_acc);

  // Buffer has room for both nibbles of a sent byte this cycle.
  assign room2 = (ob_cnt_q == 2'd0) || ((ob_cnt_q == 2'd1) && out_acc);

  assign mem_we    = in_acc && (s_axis_tuser == OP_ENQUEUE) && !fifo_full;
  assign drop_push = in_acc && (s_axis_tuser == OP_ENQUEUE) && fifo_full;
  assign mem_re    = in_acc && (s_axis_tuser == OP_TICK) && (wait_q == '0) && !fifo_empty;

  assign rs = !cmd_pend_q;

  always_comb begin
    drop_res = '{nibble: '0, reg_sel: 1'b0, display: 1'b0, dropped: 1'b1, last: 1'b1};
    hi_res   = '{nibble: rd_data_q[BYTE_W-1:NIB_W], reg_sel: rs, display: disp_sel_q,
                 dropped: 1'b0, last: 1'b0};
    lo_res   = '{nibble: rd_data_q[NIB_W-1:0], reg_sel: rs, display: disp_sel_q,
                 dropped: 1'b0, last: 1'b1};
  end

  // Pointer and wait updates, and decode of the popped byte: prefix, or send once the buffer has room.
  always_comb begin
    disp_sel_d = disp_sel_q;
    cmd_pend_d = cmd_pend_q;
    wait_d     = wait_q;
    pop_d      = pop_q;
    send_push  = 1'b0;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    if (mem_we) begin
      wr_ptr_d = ptr_next(wr_ptr_q);
    end
    if (in_acc && (s_axis_tuser == OP_TICK)) begin
      if (wait_q != '0) begin
        wait_d = wait_q - WAIT_W'(1);
      end else if (!fifo_empty) begin
        rd_ptr_d = ptr_next(rd_ptr_q);
        pop_d    = 1'b1;
      end
    end
    if (pop_q) begin
      if (!cmd_pend_q && rd_data_q[BYTE_W-1]) begin
        disp_sel_d = rd_data_q[0];
        cmd_pend_d = 1'b1;
        pop_d      = 1'b0;
      end else if (room2) begin
        send_push  = 1'b1;
        cmd_pend_d = 1'b0;
        pop_d      = 1'b0;
        // clear and home commands need the long delay
        if (cmd_pend_q && (rd_data_q[BYTE_W-1:2] == '0)) begin
          wait_d = long_wait_q;
        end else begin
          wait_d = short_wait_q;
        end
      end
    end
  end

  // Output buffer: drain the head, then append.
  always_comb begin
    ob_d     = ob_q;
    ob_cnt_d = ob_cnt_q;
    if (out_acc) begin
      ob_d[0]  = ob_q[1];
      ob_cnt_d = ob_cnt_q - 2'd1;
    end
    if (drop_push) begin
      ob_d[ob_cnt_d[0]] = drop_res;
      ob_cnt_d          = ob_cnt_d + 2'd1;
    end
    if (send_push) begin
      ob_d[0]  = hi_res;
      ob_d[1]  = lo_res;
      ob_cnt_d = 2'd2;
    end
  end

  assign m_axis_tvalid = (ob_cnt_q != 2'd0);
  assign m_axis_tdata  = {{(BYTE_W-NIB_W){1'b0}}, ob_q[0].nibble};
  assign m_axis_tuser  = {ob_q[0].dropped, ob_q[0].display, ob_q[0].reg_sel};
  assign m_axis_tlast  = ob_q[0].last;

  // FIFO memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= s_axis_tdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_wait_q <= SHORT_WAIT_RST;
      long_wait_q  <= LONG_WAIT_RST;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      disp_sel_q   <= 1'b0;
      cmd_pend_q   <= 1'b0;
      wait_q       <= '0;
      pop_q        <= 1'b0;
      ob_cnt_q     <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_SHORT_WAIT: short_wait_q <= cfg_wdata_i;
          REG_LONG_WAIT:  long_wait_q  <= cfg_wdata_i;
          default:        ;
        endcase
      end
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      disp_sel_q <= disp_sel_d;
      cmd_pend_q <= cmd_pend_d;
      wait_q     <= wait_d;
      pop_q      <= pop_d;
      ob_cnt_q   <= ob_cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dcl_checker.sv
// Port-level checker of the dual character-LCD stream sender, with its bind.
`default_nettype none
`include "dual_char_lcd_stream_sender_defines.svh"
module dcl_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [dcl_pkg::BYTE_W-1:0]     m_axis_tdata,
  input  logic [dcl_pkg::RES_USER_W-1:0] m_axis_tuser,
  input  logic                           m_axis_tlast
);
  import dcl_pkg::*;

  logic                         out_acc;
  logic                         hi_taken;
  logic                         lo_valid;
  logic                         drop_valid;
  logic                         drop_empty;
  logic                         out_stall;
  logic [BYTE_W+RES_USER_W:0]   out_word;

  assign out_acc    = m_axis_tvalid && m_axis_tready;
  assign hi_taken   = out_acc && !m_axis_tlast;
  assign lo_valid   = m_axis_tvalid && m_axis_tlast;
  assign drop_valid = m_axis_tvalid && m_axis_tuser[2];
  assign drop_empty = m_axis_tlast && (m_axis_tdata == '0) && (m_axis_tuser[1:0] == '0);
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_word   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // The low nibble of a sent byte follows its high nibble without a gap.
  `DCL_ASSERT_NEXT(a_low_nibble_follows, clk_i, rst_ni, hi_taken, lo_valid)

  // A drop report is a single, empty result.
  `DCL_ASSERT_NOW(a_drop_single, clk_i, rst_ni, drop_valid, drop_empty)

  // Both nibbles of one byte share RS and display.
  `DCL_ASSERT_NEXT(a_pair_consistent, clk_i, rst_ni, hi_taken, $stable(m_axis_tuser))

  // A stalled result holds.
  `DCL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_word))

endmodule

bind dual_char_lcd_stream_sender dcl_checker u_dcl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the dual character-LCD stream sender.
module tb;

  // Run limits: some two thousand requests, far below the cycle limit even under long stalls.
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned RANDOM_REQUESTS = 1180;
  localparam int unsigned BIG_WAIT        = 200;

  // Bytes with a meaning to the display controller.
  localparam logic [7:0] PREFIX_FIRST    = 8'h80;  // next byte is a command for display 0
  localparam logic [7:0] PREFIX_SECOND   = 8'h81;  // next byte is a command for display 1
  localparam logic [7:0] PREFIX_ALL_ONES = 8'hFF;
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_HOME        = 8'h02;
  localparam logic [7:0] CMD_LAST_LONG   = 8'h03;  // highest command with the long wait
  localparam logic [7:0] CMD_FIRST_SHORT = 8'h04;  // lowest command with the short wait
  localparam logic [7:0] CHAR_NUL        = 8'h00;
  localparam logic [7:0] CHAR_A          = 8'h41;
  localparam logic [7:0] CHAR_TOP        = 8'h7F;  // highest byte that is never a prefix
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_TILDE      = 8'h7E;

  // Clock, reset and every input of the block start at known values.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = dcl_pkg::OP_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_index_i   = dcl_pkg::REG_SHORT_WAIT;
  logic [15:0] cfg_wdata_i   = '0;

  dual_char_lcd_stream_sender uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Mirror of the block: byte queue, pointers, display latch, command mark and wait.
  logic [7:0]  lcd_queue [dcl_pkg::FIFO_DEPTH];
  int          queue_wr;
  int          queue_rd;
  logic        cur_display;
  logic        cmd_pending;
  logic [15:0] wait_left;
  logic [15:0] short_wait_set;
  logic [15:0] long_wait_set;

  // Strobes still owed by the block, oldest first.
  dcl_pkg::result_t owed_strobes [$];

  // Knobs for idling on either side.
  bit sender_gaps = 1'b1;
  bit sink_steady = 1'b0;
  int sink_stall_left;
  int sink_roll;

  // Tallies for the summary.
  int errors;
  int cycles;
  int requests_sent;
  int strobes_seen;
  int prefixes_seen;
  int drops_seen;
  int long_loads;
  int settings_written;

  // Work out what one accepted request makes the block emit, and advance the mirror.
  task automatic predict_strobes(input logic op, input logic [7:0] req_byte);
    int               nxt;
    logic [7:0]       popped;
    logic             rs;
    dcl_pkg::result_t hi;
    dcl_pkg::result_t lo;
    if (op == dcl_pkg::OP_ENQUEUE) begin
      nxt = (queue_wr + 1) % dcl_pkg::FIFO_DEPTH;
      if (nxt == queue_rd) begin
        // full: drop the byte and flag it, nothing else changes
        hi = '{nibble: '0, reg_sel: 1'b0, display: 1'b0, dropped: 1'b1, last: 1'b1};
        owed_strobes.push_back(hi);
        drops_seen++;
      end else begin
        lcd_queue[queue_wr] = req_byte;
        queue_wr = nxt;
      end
    end else if (wait_left != '0) begin
      wait_left = wait_left - 16'd1;
    end else if (queue_rd != queue_wr) begin
      popped   = lcd_queue[queue_rd];
      queue_rd = (queue_rd + 1) % dcl_pkg::FIFO_DEPTH;
      if (!cmd_pending && popped[7]) begin
        // prefix: latch the display, mark the next byte as a command
        cur_display = popped[0];
        cmd_pending = 1'b1;
        prefixes_seen++;
      end else begin
        rs = ~cmd_pending;
        hi = '{nibble: popped[7:4], reg_sel: rs, display: cur_display, dropped: 1'b0,
               last: 1'b0};
        lo = '{nibble: popped[3:0], reg_sel: rs, display: cur_display, dropped: 1'b0,
               last: 1'b1};
        owed_strobes.push_back(hi);
        owed_strobes.push_back(lo);
        // clear and home (commands 0 to 3) need the long settle time
        if (cmd_pending && popped[7:2] == '0) begin
          wait_left = long_wait_set;
          long_loads++;
        end else begin
          wait_left = short_wait_set;
        end
        cmd_pending = 1'b0;
      end
    end
  endtask

  // Gap before a request: mostly none or short, now and then long.
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!sender_gaps || roll < 55) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 24);
  endfunction

  // Offer one request at a falling edge and hold it until the block takes it.
  // tvalid is lowered here only for a gap, so back-to-back requests keep it high.
  task automatic send_request(input logic op, input logic [7:0] req_byte);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= req_byte;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_strobes(op, req_byte);
    requests_sent++;
  endtask

  // Tick requests carry random data, which the block must ignore.
  task automatic run_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(dcl_pkg::OP_TICK, 8'($urandom));
    end
  endtask

  task automatic enqueue(input logic [7:0] req_byte);
    send_request(dcl_pkg::OP_ENQUEUE, req_byte);
  endtask

  // Pause the sender until every owed strobe is out, then let a silent pop finish.
  task automatic hold_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (owed_strobes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both wait registers; only called with the block drained.
  task automatic load_waits(input logic [15:0] short_val, input logic [15:0] long_val);
    hold_until_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= dcl_pkg::REG_SHORT_WAIT;
    cfg_wdata_i <= short_val;
    @(negedge clk_i);
    cfg_index_i <= dcl_pkg::REG_LONG_WAIT;
    cfg_wdata_i <= long_val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    short_wait_set = short_val;
    long_wait_set  = long_val;
    settings_written += 2;
  endtask

  // Reset short wait: one character, then a prefixed command that takes the short wait.
  task automatic check_default_waits();
    run_ticks(1);
    enqueue(CHAR_A);
    run_ticks(1 + 38);
    enqueue(PREFIX_FIRST);
    enqueue(CMD_FIRST_SHORT);
    run_ticks(2 + 38 + 1);
    hold_until_drained();
  endtask

  // Zero waits: each code class back to back, including a prefix byte sent as a command.
  task automatic check_zero_waits();
    load_waits('0, '0);
    enqueue(CHAR_NUL);
    enqueue(PREFIX_ALL_ONES);
    enqueue(PREFIX_ALL_ONES);
    enqueue(PREFIX_FIRST);
    enqueue(CMD_LAST_LONG);
    enqueue(PREFIX_SECOND);
    enqueue(CMD_FIRST_SHORT);
    enqueue(CHAR_TOP);
    run_ticks(10);
  endtask

  // Overfill the queue while it waits, then drain it.
  task automatic check_full_queue();
    load_waits(16'd2, 16'd2);
    repeat (dcl_pkg::FIFO_DEPTH + 2) enqueue(8'($urandom));
    run_ticks((dcl_pkg::FIFO_DEPTH - 1) * 3 + 4);
  endtask

  // Large short wait: the next byte may only leave after every idle tick.
  task automatic check_longest_short_wait();
    load_waits(16'(BIG_WAIT), '0);
    enqueue(CHAR_A);
    enqueue(CHAR_TOP);
    sender_gaps = 1'b0;
    run_ticks(1 + BIG_WAIT);
    sender_gaps = 1'b1;
    load_waits('0, '0);
    run_ticks(2);
  endtask

  // Large long wait, reached through a home command on the second display.
  task automatic check_longest_long_wait();
    load_waits('0, 16'(BIG_WAIT));
    enqueue(PREFIX_SECOND);
    enqueue(CMD_HOME);
    enqueue(CHAR_A);
    sender_gaps = 1'b0;
    run_ticks(2 + BIG_WAIT);
    sender_gaps = 1'b1;
    load_waits('0, '0);
    run_ticks(2);
  endtask

  // Mostly well-formed text and prefixed commands, with ticks, noise and overfill.
  task automatic check_random_traffic();
    int          budget;
    int          start;
    int          roll;
    logic [15:0] short_pick [4];
    logic [15:0] long_pick [4];
    short_pick = '{16'd0, 16'd1, 16'd4, 16'($urandom_range(0, 6))};
    long_pick  = '{16'd0, 16'd5, 16'd0, 16'($urandom_range(0, 24))};
    budget     = RANDOM_REQUESTS / 4;
    for (int phase = 0; phase < 4; phase++) begin
      load_waits(short_pick[phase], long_pick[phase]);
      start = requests_sent;
      while (requests_sent - start < budget) begin
        sender_gaps = ($urandom_range(0, 9) != 0);
        sink_steady = ($urandom_range(0, 9) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
          repeat ($urandom_range(1, 6)) enqueue(8'($urandom_range(CHAR_SPACE, CHAR_TILDE)));
        end else if (roll < 55) begin
          enqueue(PREFIX_FIRST | 8'($urandom_range(0, 127)));
          if ($urandom_range(0, 2) == 0) begin
            enqueue(8'($urandom_range(0, 3)));
          end else begin
            enqueue(8'($urandom));
          end
        end else if (roll < 88) begin
          run_ticks($urandom_range(1, 2 * (short_wait_set + 2)));
        end else if (roll < 96) begin
          // noise: a stray byte of any value, or a lone tick
          if ($urandom_range(0, 1) == 0) enqueue(8'($urandom));
          else run_ticks(1);
        end else begin
          repeat ($urandom_range(10, 40)) enqueue(8'($urandom));
        end
      end
    end
    sender_gaps = 1'b1;
    sink_steady = 1'b0;
  endtask

  // Result side: stall at random, mostly briefly, sometimes for a long stretch.
  always @(negedge clk_i) begin
    if (!rst_ni || sink_steady) begin
      m_axis_tready <= 1'b1;
    end else if (sink_stall_left > 0) begin
      sink_stall_left <= sink_stall_left - 1;
      m_axis_tready   <= 1'b0;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else if (sink_roll < 95) begin
        m_axis_tready   <= 1'b0;
        sink_stall_left <= $urandom_range(0, 2);
      end else begin
        m_axis_tready   <= 1'b0;
        sink_stall_left <= $urandom_range(5, 30);
      end
    end
  end

  // Compare every strobe taken with the oldest one owed.
  always @(posedge clk_i) begin
    dcl_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      strobes_seen++;
      if (owed_strobes.size() == 0) begin
        $display("%0t: strobe with none owed: tdata %h tuser %b tlast %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = owed_strobes.pop_front();
        if (m_axis_tdata !== {4'b0000, want.nibble}) begin
          $display("%0t: nibble mismatch: expected %h, got %h",
                   $time, {4'b0000, want.nibble}, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== {want.dropped, want.display, want.reg_sel}) begin
          $display("%0t: dropped/display/rs mismatch: expected %b, got %b",
                   $time, {want.dropped, want.display, want.reg_sel}, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last mismatch: expected %b, got %b", $time, want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d strobes owed", $time, owed_strobes.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    queue_wr       = 0;
    queue_rd       = 0;
    cur_display    = 1'b0;
    cmd_pending    = 1'b0;
    wait_left      = '0;
    short_wait_set = dcl_pkg::SHORT_WAIT_RST;
    long_wait_set  = dcl_pkg::LONG_WAIT_RST;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_default_waits();
    check_zero_waits();
    check_full_queue();
    check_longest_short_wait();
    check_longest_long_wait();
    check_random_traffic();

    hold_until_drained();
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (owed_strobes.size() != 0) begin
      $display("%0t: %0d strobes never arrived", $time, owed_strobes.size());
      errors++;
    end

    $display("Covered %0d requests, %0d strobes, %0d prefixes, %0d dropped bytes.",
             requests_sent, strobes_seen, prefixes_seen, drops_seen);
    $display("Long waits loaded %0d times over %0d register writes; %0d errors.",
             long_loads, settings_written, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
